/* rtl/sm3_pkg.sv */
package sm3_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int WORD_COUNT  = 16;
    localparam int LEN_POS     = 56;
    localparam int ROUNDS      = 64;

    localparam logic [31:0] TJ_LOW  = 32'h79CC4519;
    localparam logic [31:0] TJ_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } in_item_t;

    typedef struct packed {
        word_t      digest_word;
        logic [2:0] word_index;
        logic       final_word;
    } out_item_t;

    function automatic word_t init_word(input logic [2:0] idx);
        word_t v;
        unique case (idx)
            3'd0: v = 32'h7380166F;
            3'd1: v = 32'h4914B2B9;
            3'd2: v = 32'h172442D7;
            3'd3: v = 32'hDA8A0600;
            3'd4: v = 32'hA96F30BC;
            3'd5: v = 32'h163138AA;
            3'd6: v = 32'hE38DEE4D;
            3'd7: v = 32'hB0FB0E4E;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic word_t rotl(input word_t x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

/* rtl/sm3_stream_if.sv */
interface sm3_stream_if #(
    parameter type PAYLOAD_T = logic
);
    logic     valid;
    logic     ready;
    PAYLOAD_T payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/sm3_ram.sv */
module sm3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* rtl/sm3_compress.sv */
// Compression unit: one round per cycle. The 16-word expansion window is
// held in a shift register and the message words are read from the block
// memory owned by the top level, one word a cycle, before the rounds start.
module sm3_cf_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sm3_pkg::word_t     cv_in [8],
    output logic [3:0]         rd_addr,
    input  sm3_pkg::word_t     rd_data,
    output logic               done,
    output sm3_pkg::word_t     cv_out [8]
);
    import sm3_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_LOAD  = 3'b010,
        C_ROUND = 3'b100
    } cstate_t;

    cstate_t    state_reg, state_next;
    logic [4:0] load_cnt_reg;
    logic [5:0] round_reg;
    word_t      win_reg [16];
    word_t      v_reg [8];
    word_t      cv_reg [8];
    logic       done_reg;

    word_t w_new, a12, ss1, ss2, ff, gg, tt1, tt2, tj;

    assign rd_addr = load_cnt_reg[3:0];
    assign done = done_reg;
    assign cv_out = v_reg;

    always_comb
    begin
        w_new = perm1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 5'd15))
                ^ rotl(win_reg[3], 5'd7) ^ win_reg[10];
        tj  = (round_reg < 6'd16) ? TJ_LOW : TJ_HIGH;
        a12 = rotl(v_reg[0], 5'd12);
        ss1 = rotl(a12 + v_reg[4] + rotl(tj, round_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (round_reg < 6'd16)
        begin
            ff = v_reg[0] ^ v_reg[1] ^ v_reg[2];
            gg = v_reg[4] ^ v_reg[5] ^ v_reg[6];
        end
        else
        begin
            ff = (v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]);
            gg = (v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]);
        end
        tt1 = ff + v_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = gg + v_reg[7] + ss1 + win_reg[0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:  if (start) state_next = C_LOAD;
            C_LOAD:  if (load_cnt_reg == 5'd16) state_next = C_ROUND;
            C_ROUND: if (round_reg == 6'(ROUNDS - 1)) state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= C_IDLE;
            load_cnt_reg <= '0;
            round_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_reg == C_IDLE)
            begin
                load_cnt_reg <= '0;
                round_reg    <= '0;
            end
            if (state_reg == C_LOAD)
            begin
                load_cnt_reg <= load_cnt_reg + 5'd1;
            end
            if (state_reg == C_ROUND)
            begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'(ROUNDS - 1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Memory read data arrives in the cycle after its address, so loads shift in
    // from count 1 through 16.
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && start)
        begin
            cv_reg <= cv_in;
            v_reg  <= cv_in;
        end
        if (state_reg == C_LOAD && load_cnt_reg != 5'd0)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= rd_data;
        end
        if (state_reg == C_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
            if (round_reg == 6'(ROUNDS - 1))
            begin
                v_reg[0] <= cv_reg[0] ^ tt1;
                v_reg[1] <= cv_reg[1] ^ v_reg[0];
                v_reg[2] <= cv_reg[2] ^ rotl(v_reg[1], 5'd9);
                v_reg[3] <= cv_reg[3] ^ v_reg[2];
                v_reg[4] <= cv_reg[4] ^ perm0(tt2);
                v_reg[5] <= cv_reg[5] ^ v_reg[4];
                v_reg[6] <= cv_reg[6] ^ rotl(v_reg[5], 5'd19);
                v_reg[7] <= cv_reg[7] ^ v_reg[6];
            end
            else
            begin
                v_reg[0] <= tt1;
                v_reg[1] <= v_reg[0];
                v_reg[2] <= rotl(v_reg[1], 5'd9);
                v_reg[3] <= v_reg[2];
                v_reg[4] <= perm0(tt2);
                v_reg[5] <= v_reg[4];
                v_reg[6] <= rotl(v_reg[5], 5'd19);
                v_reg[7] <= v_reg[6];
            end
        end
    end
endmodule

/* rtl/sm3_hash_engine.sv */
// SM3 hash engine, streaming one message byte per input transfer.
// Input channel (in_ch): data_byte, byte_present, message_end. A transfer
// with byte_present low and message_end low is ignored. message_end closes
// the message after any byte carried by the same transfer.
// Output channel (out_ch): eight transfers per message, digest_word with
// word_index 0..7 and final_word set on the last word.
// Bytes are packed into 32-bit words and written to a 16-word block memory.
// A byte that does not complete a block is only stored, and input stays
// ready. A byte that completes a block starts the compression unit, which
// reads the 16 words, runs one round per cycle and then reports done, and
// input is blocked until done.
// At message end the padding words are written one per cycle (16 minus the
// pending word count), then one compression, or two such passes when 56 or
// more bytes are pending; the first digest word follows at once.
// Reset returns the chaining value to the SM3 initial value and empties the
// buffer and length counter. A stalled receiver holds the digest word on
// the output register; no input is taken until all eight words are taken
// and S_WAIT has restored the initial value.
module sm3_hash_engine (
    input  logic  clk,
    input  logic  rst_n,
    sm3_stream_if.sink   in_ch,
    sm3_stream_if.source out_ch
);
    import sm3_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_COMP   = 6'b000010,
        S_PAD    = 6'b000100,
        S_PCOMP  = 6'b001000,
        S_OUT    = 6'b010000,
        S_WAIT   = 6'b100000
    } state_t;

    state_t      state_reg;
    word_t       cv_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [23:0] part_reg;
    logic [3:0]  pad_idx_reg;
    logic        two_blk_reg;
    logic        second_reg;
    logic [2:0]  oidx_reg;
    logic        ovalid_reg;

    logic        wr_en;
    logic [3:0]  wr_addr;
    word_t       wr_data;
    logic [3:0]  rd_addr;
    word_t       rd_data;
    logic        c_start, c_done;
    word_t       c_out [8];

    in_item_t    in_item;
    logic        take;
    logic [5:0]  pos;
    logic [63:0] bits;
    word_t       pad_word;

    sm3_ram #(.WIDTH(32), .DEPTH(WORD_COUNT)) u_block (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    sm3_cf_unit u_comp (
        .clk(clk), .rst_n(rst_n), .start(c_start), .cv_in(cv_reg),
        .rd_addr(rd_addr), .rd_data(rd_data), .done(c_done), .cv_out(c_out)
    );

    assign in_item = in_ch.payload;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign take = in_ch.valid && in_ch.ready;
    assign bits = {len_reg[60:0], 3'b000};
    assign pos = fill_reg;

    // Padding word at pad_idx_reg: pending bytes, then 0x80, zeros and, in
    // the final block, the bit length in the last two words.
    always_comb
    begin
        logic [5:0] b;
        logic [7:0] by;
        pad_word = '0;
        for (int k = 0; k < 4; k++)
        begin
            b = {pad_idx_reg, 2'(k)};
            if (second_reg)
                by = 8'h00;
            else if (b < pos)
                by = (k == 0) ? part_reg[23:16] : (k == 1) ? part_reg[15:8]
                     : part_reg[7:0];
            else if (b == pos)
                by = PAD_BYTE;
            else
                by = 8'h00;
            pad_word[31 - 8*k -: 8] = by;
        end
        if (!two_blk_reg || second_reg)
        begin
            if (pad_idx_reg == 4'd14) pad_word = bits[63:32];
            if (pad_idx_reg == 4'd15) pad_word = bits[31:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pad_idx_reg;
        wr_data = pad_word;
        c_start = 1'b0;
        if (take && in_item.byte_present && pos[1:0] == 2'd3)
        begin
            wr_en   = 1'b1;
            wr_addr = pos[5:2];
            wr_data = {part_reg, in_item.data_byte};
            c_start = (pos == 6'(BLOCK_BYTES - 1));
        end
        if (state_reg == S_PAD)
        begin
            // Words fully below the pending byte count are already stored.
            wr_en = second_reg || ({pad_idx_reg, 2'b11} >= pos)
                    || (pad_idx_reg >= 4'd14);
            c_start = (pad_idx_reg == 4'd15);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            len_reg     <= '0;
            part_reg    <= '0;
            pad_idx_reg <= '0;
            two_blk_reg <= 1'b0;
            second_reg  <= 1'b0;
            oidx_reg    <= '0;
            ovalid_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                cv_reg[i] <= init_word(3'(i));
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        logic [5:0] f;
                        logic [63:0] l;
                        f = fill_reg;
                        l = len_reg;
                        if (in_item.byte_present)
                        begin
                            unique case (f[1:0])
                                2'd0: part_reg[23:16] <= in_item.data_byte;
                                2'd1: part_reg[15:8]  <= in_item.data_byte;
                                2'd2: part_reg[7:0]   <= in_item.data_byte;
                                default: ;
                            endcase
                            f = f + 6'd1;
                            l = l + 64'd1;
                        end
                        fill_reg <= f;
                        len_reg  <= l;
                        if (in_item.byte_present && fill_reg == 6'(BLOCK_BYTES - 1))
                        begin
                            state_reg <= S_COMP;
                        end
                        else if (in_item.message_end)
                        begin
                            state_reg   <= S_PAD;
                            pad_idx_reg <= f[5:2];
                            two_blk_reg <= (f >= 6'(LEN_POS));
                            second_reg  <= 1'b0;
                        end
                        if (in_item.message_end && in_item.byte_present
                            && fill_reg == 6'(BLOCK_BYTES - 1))
                        begin
                            // Block completes and the message ends: pad after.
                            two_blk_reg <= 1'b1;
                            second_reg  <= 1'b1;
                        end
                    end
                end
                S_COMP:
                begin
                    if (c_done)
                    begin
                        cv_reg <= c_out;
                        if (second_reg)
                        begin
                            state_reg   <= S_PAD;
                            two_blk_reg <= 1'b0;
                            second_reg  <= 1'b0;
                            pad_idx_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_PAD:
                begin
                    pad_idx_reg <= pad_idx_reg + 4'd1;
                    if (pad_idx_reg == 4'd15)
                    begin
                        state_reg <= S_PCOMP;
                    end
                end
                S_PCOMP:
                begin
                    if (c_done)
                    begin
                        cv_reg <= c_out;
                        if (two_blk_reg && !second_reg)
                        begin
                            second_reg  <= 1'b1;
                            pad_idx_reg <= '0;
                            state_reg   <= S_PAD;
                        end
                        else
                        begin
                            state_reg  <= S_OUT;
                            oidx_reg   <= '0;
                            ovalid_reg <= 1'b1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            ovalid_reg <= 1'b0;
                            state_reg  <= S_WAIT;
                        end
                    end
                end
                S_WAIT:
                begin
                    fill_reg    <= '0;
                    len_reg     <= '0;
                    two_blk_reg <= 1'b0;
                    second_reg  <= 1'b0;
                    for (int i = 0; i < 8; i++)
                    begin
                        cv_reg[i] <= init_word(3'(i));
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // When a block completes with message_end, fill is zero and second_reg
    // is cleared before the padding pass, so 0x80 lands at byte 0 of word 0.
    assign out_ch.valid = ovalid_reg;
    assign out_ch.payload = '{digest_word: cv_reg[oidx_reg], word_index: oidx_reg,
                              final_word: (oidx_reg == 3'd7)};
endmodule
